// File: design/pba_pkg.sv
package pba_pkg;

    localparam int HEAP_LOG2      = 20;
    localparam int NUM_BUCKETS    = 17;
    localparam int MIN_CHUNK_LOG2 = 4;
    localparam int HDR_LOG2       = 3;
    localparam int HDR_BYTES      = 1 << HDR_LOG2;
    localparam int ADDR_W         = HEAP_LOG2;
    localparam int LINK_W         = HEAP_LOG2 + 1;
    localparam int WORD_W         = HEAP_LOG2 - HDR_LOG2;
    localparam int ENTRY_W        = LINK_W + 2;
    localparam int COUNT_W        = 17;
    localparam int BKT_W          = 5;
    localparam logic [4:0] PAGE_LOG2_RST = 5'd12;

    typedef logic [1:0] tag_t;
    localparam tag_t TAG_LINK = 2'd0;
    localparam tag_t TAG_USED = 2'd1;
    localparam tag_t TAG_FRAG = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_NOMEM   = 2'd2;

    typedef enum logic [1:0] {
        OP_BAD,
        OP_NOFIT,
        OP_ALLOC,
        OP_FREE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BKT_W-1:0]  bucket;
        logic [ADDR_W-1:0] gap;
        logic [ADDR_W-1:0] addr;
    } req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_REFILL,
        BK_RD_HEAD,
        BK_POP,
        BK_FRAG,
        BK_F_CHK,
        BK_F_CHK2
    } back_state_t;

endpackage

// File: design/pow2_bucket_allocator_core.sv
// Power-of-two bucket allocator over a 1 MiB heap.
// Input stream s_*: one item per allocate or free request. The result
// stream m_* returns one item per request: address, status, bucket.
// cfg_*: write of page_log2 (reset 12); write only while the block is idle.
// A front stage classifies each item (alignment check, bucket choice) and
// places it in a two-entry queue; a back sequencer does the header-memory
// work, one read or one write of the header RAM per cycle.
// Back steps per item: invalid or heap-full requests end in idle; allocate
// from a non-empty list reads the head, then writes the used header (then a
// fragment header for an alignment gap); free reads the header, then writes
// the link if valid (after following any fragment header). An empty list first
// writes a link header per chunk of max(page, chunk), then reads the new head.
// Reset (aresetn low, synchronous) empties all free lists, clears the break
// pointer and marks the heap unstarted; the header RAM is not cleared.
// When m_tready is low the result is held, the back holds its next item and
// the queue keeps taking input until full.
module pow2_bucket_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[0], request_size[21:1], align_log2[26:22], block_address[46:27], zero pad
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_address[19:0], status[21:20], bucket_index[26:22], zero pad
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import pba_pkg::*;

    logic [4:0]  page_log2_reg;
    req_t        front_req, q_head;
    logic        q_full, q_not_empty, q_pop;
    logic [19:0] m_addr;
    logic [1:0]  m_status;
    logic [4:0]  m_bucket;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_log2_reg <= PAGE_LOG2_RST;
        end else if (cfg_valid) begin
            page_log2_reg <= cfg_data;
        end
    end

    pba_front u_front (
        .cmd           (s_tdata[0]),
        .request_size  (s_tdata[21:1]),
        .align_log2    (s_tdata[26:22]),
        .block_address (s_tdata[46:27]),
        .page_log2     (page_log2_reg),
        .req           (front_req)
    );

    pba_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid && !q_full),
        .push_data (front_req),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_head)
    );

    pba_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .page_log2 (page_log2_reg),
        .q_valid   (q_not_empty),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_addr    (m_addr),
        .m_status  (m_status),
        .m_bucket  (m_bucket)
    );

    assign m_tdata = {5'b0, m_bucket, m_status, m_addr};

endmodule

// File: design/pba_front.sv
module pba_front (
    input  logic                   cmd,
    input  logic [20:0]            request_size,
    input  logic [4:0]             align_log2,
    input  logic [19:0]            block_address,
    input  logic [4:0]             page_log2,
    output pba_pkg::req_t          req
);
    import pba_pkg::*;

    logic [31:0] gap32;
    logic [32:0] need8;
    logic        fit_any;
    logic [BKT_W-1:0] fit_b;

    always_comb begin
        gap32 = (align_log2 > 5'(HDR_LOG2)) ? ((32'd1 << align_log2) - 32'(HDR_BYTES)) : 32'd0;
        need8 = 33'(request_size) + 33'(gap32) + 33'(HDR_BYTES);
        fit_any = 1'b0;
        fit_b   = '0;
        // scan down so the smallest fitting bucket wins
        for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
            if (need8 <= (33'd1 << (i + MIN_CHUNK_LOG2))) begin
                fit_any = 1'b1;
                fit_b   = BKT_W'(i);
            end
        end
    end

    always_comb begin
        req.bucket = fit_b;
        req.gap    = gap32[ADDR_W-1:0];
        req.addr   = block_address;
        if (cmd) begin
            req.op = OP_FREE;
        end else if (align_log2 > page_log2) begin
            req.op = OP_BAD;
        end else if (!fit_any) begin
            req.op = OP_NOFIT;
        end else begin
            req.op = OP_ALLOC;
        end
    end

endmodule

// File: design/pba_queue.sv
module pba_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pba_pkg::req_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output pba_pkg::req_t pop_data
);
    import pba_pkg::*;

    req_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/pba_back.sv
module pba_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [4:0]    page_log2,
    input  logic          q_valid,
    input  pba_pkg::req_t q_data,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [19:0]   m_addr,
    output logic [1:0]    m_status,
    output logic [4:0]    m_bucket
);
    import pba_pkg::*;

    localparam logic [LINK_W-1:0] HEAP_BYTES = LINK_W'(1) << HEAP_LOG2;

    back_state_t state_reg, state_next;

    logic [ENTRY_W-1:0] hdr_mem [1 << WORD_W];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic [LINK_W-1:0]  heads_reg  [NUM_BUCKETS];
    logic [COUNT_W-1:0] counts_reg [NUM_BUCKETS];
    logic [LINK_W-1:0]  bp_reg;
    logic               started_reg;
    logic [BKT_W-1:0]   b_reg;
    logic [ADDR_W-1:0]  gap_reg;
    logic [ADDR_W-1:0]  head_reg;
    logic [ADDR_W-1:0]  hdr_reg;
    logic [LINK_W-1:0]  a_reg, end_reg, csize_reg;

    logic               m_valid_reg;
    logic [19:0]        m_addr_reg;
    logic [1:0]         m_status_reg;
    logic [4:0]         m_bucket_reg;

    // idle-state decode
    logic              can_go;
    logic [LINK_W-1:0] head_q, csize_q, memsize_q;
    logic [5:0]        clog_q, mlog_q;
    logic              exhausted;
    logic              fbad;
    logic [ADDR_W-1:0] fhdr;

    // free-path decode of the header word
    tag_t              etag;
    logic [LINK_W-1:0] epay, offgap;
    logic              offok, frag_bad, fin_ok;
    logic [BKT_W-1:0]  fb;
    logic [ADDR_W-1:0] adj_hdr;

    logic              refill_last;
    logic [LINK_W-1:0] user_sum;

    // memory port controls
    logic               we, re;
    logic [WORD_W-1:0]  wa, ra;
    logic [ENTRY_W-1:0] wd;
    logic               emit;
    logic [19:0]        e_addr;
    logic [1:0]         e_status;
    logic [4:0]         e_bucket;

    always_comb begin
        can_go    = q_valid && (!m_valid_reg || m_ready);
        head_q    = heads_reg[q_data.bucket];
        clog_q    = 6'(q_data.bucket) + 6'(MIN_CHUNK_LOG2);
        csize_q   = LINK_W'(1) << clog_q;
        mlog_q    = (6'(page_log2) > clog_q) ? 6'(page_log2) : clog_q;
        memsize_q = LINK_W'(1) << mlog_q[4:0];
        exhausted = (mlog_q > 6'(HEAP_LOG2)) || (bp_reg > (HEAP_BYTES - memsize_q));
        fhdr      = q_data.addr - ADDR_W'(HDR_BYTES);
        fbad      = !started_reg || (q_data.addr == '0) ||
                    (q_data.addr[HDR_LOG2-1:0] != '0);

        etag     = rd_data_reg[ENTRY_W-1 -: 2];
        epay     = rd_data_reg[LINK_W-1:0];
        offgap   = epay - LINK_W'(HDR_BYTES);
        offok    = (etag == TAG_FRAG) && (epay > LINK_W'(HDR_BYTES)) &&
                   ((epay & (epay - LINK_W'(1))) == '0) &&
                   (32'(epay) <= (32'd1 << page_log2));
        frag_bad = offok && (offgap > LINK_W'(hdr_reg));
        adj_hdr  = hdr_reg - offgap[ADDR_W-1:0];
        fin_ok   = (etag == TAG_USED) && (epay < LINK_W'(NUM_BUCKETS));
        fb       = epay[BKT_W-1:0];

        refill_last = (a_reg + csize_reg) >= end_reg;
        user_sum    = LINK_W'(head_reg) + LINK_W'(HDR_BYTES) + LINK_W'(gap_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (can_go) begin
                    unique case (q_data.op)
                        OP_ALLOC: begin
                            if (head_q[HEAP_LOG2]) begin
                                state_next = BK_POP;
                            end else if (!exhausted) begin
                                state_next = BK_REFILL;
                            end
                        end
                        OP_FREE: begin
                            if (!fbad) begin
                                state_next = BK_F_CHK;
                            end
                        end
                        default: state_next = BK_IDLE;
                    endcase
                end
            end
            BK_REFILL: begin
                if (refill_last) begin
                    state_next = BK_RD_HEAD;
                end
            end
            BK_RD_HEAD: state_next = BK_POP;
            BK_POP:     state_next = (gap_reg != '0) ? BK_FRAG : BK_IDLE;
            BK_FRAG:    state_next = BK_IDLE;
            BK_F_CHK:   state_next = (offok && !frag_bad) ? BK_F_CHK2 : BK_IDLE;
            BK_F_CHK2:  state_next = BK_IDLE;
            default:    state_next = BK_IDLE;
        endcase
    end

    // outputs: memory port, queue pop, result
    always_comb begin
        q_pop    = 1'b0;
        we       = 1'b0;
        re       = 1'b0;
        wa       = '0;
        ra       = '0;
        wd       = '0;
        emit     = 1'b0;
        e_addr   = '0;
        e_status = STAT_INVALID;
        e_bucket = '0;
        unique case (state_reg)
            BK_IDLE: begin
                if (can_go) begin
                    q_pop = 1'b1;
                    unique case (q_data.op)
                        OP_ALLOC: begin
                            if (head_q[HEAP_LOG2]) begin
                                re = 1'b1;
                                ra = head_q[ADDR_W-1:HDR_LOG2];
                            end else if (exhausted) begin
                                emit     = 1'b1;
                                e_status = STAT_NOMEM;
                                e_bucket = q_data.bucket;
                            end
                        end
                        OP_FREE: begin
                            if (fbad) begin
                                emit = 1'b1;
                            end else begin
                                re = 1'b1;
                                ra = fhdr[ADDR_W-1:HDR_LOG2];
                            end
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            BK_REFILL: begin
                we = 1'b1;
                wa = a_reg[ADDR_W-1:HDR_LOG2];
                wd = refill_last ? {TAG_LINK, LINK_W'(0)}
                                 : {TAG_LINK, HEAP_BYTES | (a_reg + csize_reg)};
            end
            BK_RD_HEAD: begin
                re = 1'b1;
                ra = head_reg[ADDR_W-1:HDR_LOG2];
            end
            BK_POP: begin
                we = 1'b1;
                wa = head_reg[ADDR_W-1:HDR_LOG2];
                wd = {TAG_USED, LINK_W'(b_reg)};
                if (gap_reg == '0) begin
                    emit     = 1'b1;
                    e_addr   = user_sum[19:0];
                    e_status = STAT_OK;
                    e_bucket = b_reg;
                end
            end
            BK_FRAG: begin
                we       = 1'b1;
                wa       = user_sum[ADDR_W-1:HDR_LOG2] - WORD_W'(1);
                wd       = {TAG_FRAG, LINK_W'(gap_reg) + LINK_W'(HDR_BYTES)};
                emit     = 1'b1;
                e_addr   = user_sum[19:0];
                e_status = STAT_OK;
                e_bucket = b_reg;
            end
            BK_F_CHK, BK_F_CHK2: begin
                if (state_reg == BK_F_CHK && offok && !frag_bad) begin
                    re = 1'b1;
                    ra = adj_hdr[ADDR_W-1:HDR_LOG2];
                end else begin
                    emit = 1'b1;
                    if (!frag_bad && fin_ok) begin
                        we       = 1'b1;
                        wa       = hdr_reg[ADDR_W-1:HDR_LOG2];
                        wd       = {TAG_LINK, heads_reg[fb]};
                        e_status = STAT_OK;
                        e_bucket = fb;
                    end
                end
            end
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            hdr_mem[wa] <= wd;
        end
        if (re) begin
            rd_data_reg <= hdr_mem[ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            bp_reg      <= '0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                heads_reg[i]  <= '0;
                counts_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == BK_IDLE && can_go &&
                (q_data.op == OP_ALLOC || q_data.op == OP_NOFIT)) begin
                started_reg <= 1'b1;
            end
            if (state_reg == BK_REFILL && refill_last) begin
                heads_reg[b_reg] <= HEAP_BYTES | bp_reg;
                bp_reg           <= end_reg;
            end
            if (state_reg == BK_POP) begin
                heads_reg[b_reg]  <= rd_data_reg[LINK_W-1:0];
                counts_reg[b_reg] <= counts_reg[b_reg] + COUNT_W'(1);
            end
            if (we && (state_reg == BK_F_CHK || state_reg == BK_F_CHK2)) begin
                heads_reg[fb]  <= HEAP_BYTES | LINK_W'(hdr_reg);
                counts_reg[fb] <= counts_reg[fb] - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_addr_reg   <= e_addr;
            m_status_reg <= e_status;
            m_bucket_reg <= e_bucket;
        end
        if (state_reg == BK_IDLE && can_go) begin
            b_reg     <= q_data.bucket;
            gap_reg   <= q_data.gap;
            head_reg  <= head_q[HEAP_LOG2] ? head_q[ADDR_W-1:0] : bp_reg[ADDR_W-1:0];
            a_reg     <= bp_reg;
            end_reg   <= bp_reg + memsize_q;
            csize_reg <= csize_q;
            hdr_reg   <= fhdr;
        end
        if (state_reg == BK_REFILL) begin
            a_reg <= a_reg + csize_reg;
        end
        if (state_reg == BK_F_CHK && offok && !frag_bad) begin
            hdr_reg <= adj_hdr;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_addr   = m_addr_reg;
    assign m_status = m_status_reg;
    assign m_bucket = m_bucket_reg;

    a_bp_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        bp_reg <= HEAP_BYTES)
        else $error("break pointer past heap end");

    a_refill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_REFILL |-> a_reg < end_reg)
        else $error("refill cursor out of range");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_ready))
        else $error("result overwrites undelivered item");

    a_head_after_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_RD_HEAD |-> heads_reg[b_reg][HEAP_LOG2])
        else $error("free list empty after refill");

endmodule

// File: test/pow2_bucket_allocator_core_tb.sv
module pow2_bucket_allocator_core_tb;
    import pba_pkg::*;

    localparam int  WORDS     = 1 << WORD_W;
    localparam longint HEAP   = 64'd1 << HEAP_LOG2;
    localparam int  CYC_LIMIT = 3000000;
    localparam int  CMD_ALLOC = 0;
    localparam int  CMD_FREE  = 1;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        st;
        logic [BKT_W-1:0]  bkt;
    } alloc_res_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    pow2_bucket_allocator_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    // shadow allocator state
    logic [ENTRY_W-1:0] hdr_mem [WORDS];
    bit                 hdr_written [WORDS];
    logic [LINK_W-1:0]  free_heads [NUM_BUCKETS];
    longint             brk_ptr;
    logic [COUNT_W-1:0] used_cnt [NUM_BUCKETS];
    bit                 heap_on;
    int                 pg_log2;

    logic [47:0]  req_q [$];
    alloc_res_t   result_q [$];
    logic [19:0]  live_q [$];
    logic [19:0]  freed_q [$];

    int errors = 0;
    int cycles = 0;
    int s_idle_pct = 0;
    int m_idle_pct = 0;
    int stall_req = 0;
    int stall_ack = 0;
    int stall_left = 0;

    function automatic void hdr_put(longint a, tag_t tg, longint payload);
        int w;
        w = int'((a >> HDR_LOG2) & (WORDS - 1));
        hdr_mem[w] = {tg, payload[LINK_W-1:0]};
        hdr_written[w] = 1;
    endfunction

    function automatic logic [ENTRY_W-1:0] hdr_get(longint a);
        return hdr_mem[int'((a >> HDR_LOG2) & (WORDS - 1))];
    endfunction

    function automatic bit hdr_seen(longint a);
        return hdr_written[int'((a >> HDR_LOG2) & (WORDS - 1))];
    endfunction

    function automatic alloc_res_t do_alloc(longint sz, int al);
        alloc_res_t r;
        longint gap, need, csize, mem, a, head, user, page;
        int b;
        r = '{0, STAT_INVALID, 0};
        if (al > pg_log2) return r;
        heap_on = 1;
        gap = (al > HDR_LOG2) ? (64'd1 << al) - HDR_BYTES : 0;
        need = sz + gap;
        for (b = 0; b < NUM_BUCKETS; b++) begin
            csize = 64'd1 << (b + MIN_CHUNK_LOG2);
            if (need <= csize - HDR_BYTES) break;
        end
        if (b >= NUM_BUCKETS) return r;
        csize = 64'd1 << (b + MIN_CHUNK_LOG2);
        if (!free_heads[b][HEAP_LOG2]) begin
            page = 64'd1 << pg_log2;
            mem = (page > csize) ? page : csize;
            if (mem > HEAP || brk_ptr > HEAP - mem) begin
                r.st = STAT_NOMEM;
                r.bkt = b;
                return r;
            end
            for (a = brk_ptr; a + csize < brk_ptr + mem; a += csize)
                hdr_put(a, TAG_LINK, HEAP | (a + csize));
            hdr_put(a, TAG_LINK, 0);
            free_heads[b] = HEAP | brk_ptr;
            brk_ptr += mem;
        end
        head = free_heads[b][HEAP_LOG2-1:0];
        free_heads[b] = hdr_get(head)[LINK_W-1:0];
        used_cnt[b]++;
        hdr_put(head, TAG_USED, b);
        user = head + HDR_BYTES;
        if (gap > 0) begin
            user += gap;
            hdr_put(user - HDR_BYTES, TAG_FRAG, HDR_BYTES + gap);
        end
        r.addr = user[ADDR_W-1:0];
        r.st = STAT_OK;
        r.bkt = b;
        return r;
    endfunction

    // follows a fragment header back to the chunk header; -1 if below the heap
    function automatic longint chunk_of(longint addr);
        longint h, off;
        logic [ENTRY_W-1:0] e;
        h = addr - HDR_BYTES;
        e = hdr_get(h);
        if (tag_t'(e[ENTRY_W-1:LINK_W]) == TAG_FRAG) begin
            off = e[LINK_W-1:0];
            if (off > HDR_BYTES && (off & (off - 1)) == 0 && off <= (64'd1 << pg_log2)) begin
                if (off - HDR_BYTES > h) return -1;
                h -= off - HDR_BYTES;
            end
        end
        return h;
    endfunction

    function automatic alloc_res_t do_free(longint addr);
        alloc_res_t r;
        longint h;
        logic [ENTRY_W-1:0] e;
        int b;
        r = '{0, STAT_INVALID, 0};
        if (!heap_on || addr == 0 || addr % HDR_BYTES != 0) return r;
        h = chunk_of(addr);
        if (h < 0) return r;
        e = hdr_get(h);
        if (tag_t'(e[ENTRY_W-1:LINK_W]) != TAG_USED || e[LINK_W-1:0] >= NUM_BUCKETS)
            return r;
        b = e[LINK_W-1:0];
        hdr_put(h, TAG_LINK, free_heads[b]);
        free_heads[b] = HEAP | h;
        used_cnt[b]--;
        r.st = STAT_OK;
        r.bkt = b;
        return r;
    endfunction

    // true when a free of addr touches no header word that was never written
    function automatic bit free_is_legal(longint addr);
        longint h;
        if (!heap_on || addr == 0 || addr % HDR_BYTES != 0) return 1;
        if (!hdr_seen(addr - HDR_BYTES)) return 0;
        h = chunk_of(addr);
        return (h < 0) || hdr_seen(h);
    endfunction

    task automatic push_req(int cmd, longint sz, int al, longint addr);
        alloc_res_t r;
        if (cmd == CMD_ALLOC) begin
            r = do_alloc(sz, al);
            if (r.st == STAT_OK) live_q.push_back(r.addr);
        end else begin
            r = do_free(addr);
            if (r.st == STAT_OK) freed_q.push_back(addr[19:0]);
        end
        result_q.push_back(r);
        req_q.push_back({1'b0, addr[19:0], al[4:0], sz[20:0], cmd[0]});
    endtask

    task automatic free_live(int idx);
        logic [19:0] a;
        a = live_q[idx];
        live_q.delete(idx);
        push_req(CMD_FREE, 0, 0, a);
    endtask

    task automatic rand_items(int n);
        int k, sel, al;
        longint sz, a;
        k = 0;
        while (k < n) begin
            sel = $urandom_range(0, 99);
            if (sel < 55 || (sel < 90 && live_q.size() == 0)) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)      sz = $urandom_range(0, 100);
                else if (sel < 90) sz = $urandom_range(100, 3000);
                else if (sel < 98) sz = $urandom_range(3000, 70000);
                else               sz = $urandom_range(0, 1048576);
                al = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                 : $urandom_range(0, pg_log2);
                push_req(CMD_ALLOC, sz, al, 0);
                k++;
            end else if (sel < 90) begin
                free_live($urandom_range(0, live_q.size() - 1));
                k++;
            end else begin
                // noise: double free, misaligned, zero or arbitrary address
                sel = $urandom_range(0, 3);
                if (sel == 0 && freed_q.size() > 0)
                    a = freed_q[$urandom_range(0, freed_q.size() - 1)];
                else if (sel == 1 && live_q.size() > 0)
                    a = live_q[$urandom_range(0, live_q.size() - 1)] + $urandom_range(1, 7);
                else if (sel == 2)
                    a = 0;
                else
                    a = $urandom_range(0, 20'hFFFFF) & ~64'd7;
                a &= 20'hFFFFF;
                if (free_is_legal(a)) begin
                    push_req(CMD_FREE, 0, 0, a);
                    k++;
                end
            end
        end
    endtask

    task automatic drain(int extra);
        while (req_q.size() != 0 || s_tvalid || result_q.size() != 0)
            @(negedge aclk);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic write_page(int v);
        @(posedge aclk);
        cfg_valid <= 1;
        cfg_data <= v[4:0];
        forever begin
            @(negedge aclk);
            if (cfg_ready) break;
        end
        @(posedge aclk);
        cfg_valid <= 0;
        pg_log2 = v;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (req_q.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                s_tvalid <= 1;
                s_tdata <= req_q.pop_front();
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // receiver ready, with a long hold-off when one is requested
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 0;
            stall_left <= stall_left - 1;
        end else if (stall_ack != stall_req) begin
            m_tready <= 0;
            stall_left <= 400;
            stall_ack <= stall_ack + 1;
        end else begin
            m_tready <= aresetn && ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        alloc_res_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected item", m_tdata, 0);
            end else begin
                w = result_q.pop_front();
                if (m_tdata[19:0] != w.addr)  report_mismatch("address", m_tdata[19:0], w.addr);
                if (m_tdata[21:20] != w.st)   report_mismatch("status", m_tdata[21:20], w.st);
                if (m_tdata[26:22] != w.bkt)  report_mismatch("bucket", m_tdata[26:22], w.bkt);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < WORDS; i++) begin
            hdr_mem[i] = '0;
            hdr_written[i] = 0;
        end
        for (int b = 0; b < NUM_BUCKETS; b++) begin
            free_heads[b] = '0;
            used_cnt[b] = '0;
        end
        brk_ptr = 0;
        heap_on = 0;
        pg_log2 = PAGE_LOG2_RST;

        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: reset page size
        push_req(CMD_FREE, 0, 0, 20'hFFFFF);        // before heap start
        push_req(CMD_ALLOC, 0, 31, 0);              // alignment above page
        push_req(CMD_FREE, 0, 0, 8);
        push_req(CMD_ALLOC, 0, 0, 0);
        push_req(CMD_ALLOC, 1048576, 0, 0);         // no bucket fits
        push_req(CMD_ALLOC, 1048575, 0, 0);
        push_req(CMD_ALLOC, 8, 0, 0);
        push_req(CMD_ALLOC, 9, 0, 0);
        push_req(CMD_ALLOC, 0, 12, 0);              // largest fragment gap
        push_req(CMD_ALLOC, 100, 4, 0);
        push_req(CMD_ALLOC, 100, 3, 0);
        push_req(CMD_ALLOC, 1048568, 0, 0);         // heap exhausted
        push_req(CMD_ALLOC, 2000, 13, 0);
        push_req(CMD_FREE, 0, 0, 0);
        push_req(CMD_FREE, 0, 0, live_q[0] + 4);
        free_live(3);
        free_live(2);
        push_req(CMD_FREE, 0, 0, freed_q[0]);       // double free
        push_req(CMD_ALLOC, 5, 0, 0);
        push_req(CMD_ALLOC, 0, 12, 0);
        free_live(0);
        free_live(live_q.size() - 1);
        drain(8);

        s_idle_pct = 6;
        m_idle_pct = 85;
        write_page(4);
        rand_items(140);
        drain(8);

        s_idle_pct = 85;
        m_idle_pct = 6;
        write_page(8);
        rand_items(140);
        drain(8);

        s_idle_pct = 0;
        m_idle_pct = 0;
        write_page(12);
        rand_items(120);
        @(negedge aclk);
        stall_req = stall_req + 1;
        drain(8);

        write_page(20);
        rand_items(40);
        drain(20);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: sim.f
design/pba_pkg.sv
design/pba_front.sv
design/pba_queue.sv
design/pba_back.sv
design/pow2_bucket_allocator_core.sv
test/pow2_bucket_allocator_core_tb.sv
